// ===== hdl/bsl_pkg.sv =====
`timescale 1ns / 1ps

package bsl_pkg;

    localparam int MAX_BUTTONS = 8;
    localparam int MAX_CODE    = 8;
    localparam int TIMER_BITS  = 32;

    localparam int LAMP_W  = 8;
    localparam int DIGIT_W = 3;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 3;
    localparam int WORD_W  = 24;
    localparam int DUR_W   = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int HALF_RIGHT = 250;

    localparam logic [1:0] ACT_SCAN    = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_FORCE   = 2'd2;

    localparam logic [2:0] REG_BUTTON_COUNT = 3'd0;
    localparam logic [2:0] REG_CODE_LENGTH  = 3'd1;
    localparam logic [2:0] REG_CODE_WORD    = 3'd2;
    localparam logic [2:0] REG_WRONG_TICKS  = 3'd3;
    localparam logic [2:0] REG_RIGHT_TICKS  = 3'd4;

    typedef enum logic [1:0] {
        PH_ENTER  = 2'd0,
        PH_WRONG  = 2'd1,
        PH_RIGHT  = 2'd2,
        PH_SOLVED = 2'd3
    } phase_t;

    typedef struct packed {
        logic start;
        logic scan_step;
        logic check_step;
        logic judge;
        logic show;
    } bsl_cmd_t;

    typedef struct packed {
        logic scan_needed;
        logic scan_last;
        logic count_zero;
        logic check_last;
    } bsl_status_t;

endpackage

// ===== hdl/bsl_ctrl.sv =====
`timescale 1ns / 1ps

module bsl_ctrl
    import bsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  bsl_status_t status,
    output bsl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_JUDGE,
        S_SHOW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.start = in_valid;
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = status.scan_needed;
                if (!status.scan_needed || status.scan_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check_step = !status.count_zero;
                if (status.count_zero || status.check_last)
                begin
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                cmd.judge  = 1'b1;
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                cmd.show = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.show)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/bsl_dp.sv =====
`timescale 1ns / 1ps

module bsl_dp
    import bsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  bsl_cmd_t           cmd,
    output bsl_status_t        status,
    input  logic [1:0]         action,
    input  logic [LAMP_W-1:0]  button_levels,
    input  logic [CNT_W-1:0]   button_count,
    input  logic [CNT_W-1:0]   code_length,
    input  logic [WORD_W-1:0]  code_word,
    input  logic [DUR_W-1:0]   wrong_show_ticks,
    input  logic [DUR_W-1:0]   right_show_ticks,
    output logic [LAMP_W-1:0]  lamps_lit,
    output logic [1:0]         phase,
    output logic               solved_pulse
);

    localparam int RW    = $clog2(HALF_RIGHT);
    localparam int CMP_W = DUR_W + 1;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    function automatic logic [DIGIT_W-1:0] code_digit(logic [WORD_W-1:0] w,
                                                      logic [IDX_W-1:0] pos);
        logic [WORD_W-1:0] s;
        s = w >> (DIGIT_W * int'(pos));
        return s[DIGIT_W-1:0];
    endfunction

    function automatic logic [LAMP_W-1:0] lamp_bit(logic [DIGIT_W-1:0] d);
        return LAMP_W'(1) << d;
    endfunction

    function automatic logic [LAMP_W-1:0] low_mask(logic [CNT_W-1:0] n);
        logic [LAMP_W-1:0] m;
        for (int i = 0; i < LAMP_W; i++)
        begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    // Code lamps alternate by position; a later position wins on a shared lamp.
    function automatic logic [LAMP_W-1:0] right_lamps(logic [WORD_W-1:0] w,
                                                      logic [CNT_W-1:0] n,
                                                      logic p);
        logic [LAMP_W-1:0]  acc;
        logic [DIGIT_W-1:0] d;
        acc = '0;
        for (int i = 0; i < MAX_CODE; i++)
        begin
            if (i < int'(n))
            begin
                d = w[DIGIT_W*i +: DIGIT_W];
                acc[d] = ((p ^ i[0]) == 1'b0);
            end
        end
        return acc;
    endfunction

    logic [CNT_W-1:0]      nb;
    logic [CNT_W-1:0]      len;
    logic [LAMP_W-1:0]     mask;

    phase_t                phase_reg, phase_next;
    logic [MAX_BUTTONS-1:0] held_reg, held_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic [RW-1:0]         sub_reg, sub_next;
    logic [1:0]            quarter_reg, quarter_next;
    logic [LAMP_W-1:0]     hold_reg, hold_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  force_reg, force_next;
    logic                  pulse_reg, pulse_next;
    logic                  mismatch_reg, mismatch_next;

    logic [DIGIT_W-1:0]    seq_mem [MAX_CODE];
    logic                  seq_we;
    logic [IDX_W-1:0]      seq_waddr;
    logic [DIGIT_W-1:0]    seq_wdata;
    logic [LAMP_W-1:0]     levels_reg, levels_next;
    logic [DIGIT_W-1:0]    last_reg, last_next;
    logic [LAMP_W-1:0]     acc_reg, acc_next;
    logic [LAMP_W-1:0]     lamps_reg, lamps_next;
    phase_t                ph_out_reg, ph_out_next;
    logic                  pulse_out_reg, pulse_out_next;

    logic                  el_max;
    logic                  wrong_end;
    logic                  right_end;
    logic                  pressed;
    logic [DIGIT_W-1:0]    rd_digit;
    logic [DIGIT_W-1:0]    btn;
    logic [LAMP_W-1:0]     show_lamps;
    phase_t                show_phase;

    assign nb = (button_count == '0) ? CNT_W'(1) :
                (button_count > CNT_W'(MAX_BUTTONS)) ? CNT_W'(MAX_BUTTONS) : button_count;
    assign len = (code_length == '0) ? CNT_W'(1) :
                 (code_length > CNT_W'(MAX_CODE)) ? CNT_W'(MAX_CODE) : code_length;
    assign mask = low_mask(nb);

    assign el_max    = (elapsed_reg == TIMER_MAX);
    assign wrong_end = (CMP_W'(elapsed_reg) >= CMP_W'(wrong_show_ticks)) || el_max;
    assign right_end = (CMP_W'(elapsed_reg) >= CMP_W'(right_show_ticks)) || el_max;

    assign status.scan_needed = (phase_reg == PH_ENTER) && !force_reg;
    assign status.scan_last   = (CNT_W'(idx_reg) == nb - CNT_W'(1));
    assign status.count_zero  = (count_reg == '0);
    assign status.check_last  = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));

    assign rd_digit = seq_mem[idx_reg];
    assign btn      = DIGIT_W'(idx_reg);
    assign pressed  = !levels_reg[idx_reg];

    always_comb
    begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        count_next    = count_reg;
        elapsed_next  = elapsed_reg;
        sub_next      = sub_reg;
        quarter_next  = quarter_reg;
        hold_next     = hold_reg;
        idx_next      = idx_reg;
        force_next    = force_reg;
        pulse_next    = pulse_reg;
        mismatch_next = mismatch_reg;
        levels_next   = levels_reg;
        last_next     = last_reg;
        acc_next      = acc_reg;
        lamps_next    = lamps_reg;
        ph_out_next   = ph_out_reg;
        pulse_out_next = pulse_out_reg;
        seq_we        = 1'b0;
        seq_waddr     = count_reg[IDX_W-1:0];
        seq_wdata     = btn;
        show_lamps    = '0;
        show_phase    = phase_reg;

        if (cmd.start)
        begin
            levels_next   = button_levels;
            force_next    = (action == ACT_FORCE);
            pulse_next    = 1'b0;
            acc_next      = '0;
            idx_next      = '0;
            mismatch_next = 1'b0;
            if (action == ACT_FORCE)
            begin
                phase_next   = PH_RIGHT;
                elapsed_next = '0;
                sub_next     = '0;
                quarter_next = '0;
            end
            else
            begin
                if ((phase_reg == PH_WRONG || phase_reg == PH_RIGHT) && !el_max)
                begin
                    elapsed_next = elapsed_reg + TIMER_BITS'(1);
                    if (sub_reg == RW'(HALF_RIGHT - 1))
                    begin
                        sub_next     = '0;
                        quarter_next = quarter_reg + 2'd1;
                    end
                    else
                    begin
                        sub_next = sub_reg + RW'(1);
                    end
                end
                if (action == ACT_RESTART)
                begin
                    phase_next = PH_ENTER;
                    count_next = '0;
                    hold_next  = '0;
                end
            end
        end

        if (cmd.scan_step)
        begin
            if (pressed && !held_reg[idx_reg])
            begin
                held_next[idx_reg] = 1'b1;
            end
            else if (!pressed && held_reg[idx_reg])
            begin
                held_next[idx_reg] = 1'b0;
                if ((count_reg < len) && ((count_reg == '0) || (last_reg != btn)))
                begin
                    seq_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    last_next  = btn;
                end
            end
            idx_next = status.scan_last ? '0 : idx_reg + IDX_W'(1);
        end

        if (cmd.check_step)
        begin
            acc_next = acc_reg | lamp_bit(rd_digit);
            if (rd_digit != code_digit(code_word, idx_reg))
            begin
                mismatch_next = 1'b1;
            end
            idx_next = status.check_last ? '0 : idx_reg + IDX_W'(1);
        end

        if (cmd.judge && status.scan_needed && !status.count_zero)
        begin
            if (mismatch_reg)
            begin
                phase_next   = PH_WRONG;
                elapsed_next = '0;
                sub_next     = '0;
                quarter_next = '0;
            end
            else if (count_reg == len)
            begin
                phase_next   = PH_RIGHT;
                elapsed_next = '0;
                sub_next     = '0;
                quarter_next = '0;
                pulse_next   = 1'b1;
            end
        end

        if (cmd.show)
        begin
            case (phase_reg)
                PH_WRONG:
                begin
                    if (wrong_end)
                    begin
                        count_next = '0;
                        show_phase = PH_ENTER;
                    end
                    else if (!quarter_reg[1])
                    begin
                        show_lamps = acc_reg;
                    end
                end
                PH_RIGHT:
                begin
                    if (right_end)
                    begin
                        hold_next  = low_mask(len) & mask;
                        show_phase = PH_SOLVED;
                        show_lamps = low_mask(len) & mask;
                    end
                    else
                    begin
                        show_lamps = right_lamps(code_word, len, quarter_reg[0]);
                    end
                end
                PH_ENTER:
                begin
                    show_lamps = acc_reg;
                end
                PH_SOLVED:
                begin
                    show_lamps = hold_reg;
                end
                default:
                begin
                    show_lamps = '0;
                end
            endcase
            phase_next     = show_phase;
            lamps_next     = show_lamps & mask;
            ph_out_next    = show_phase;
            pulse_out_next = pulse_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ENTER;
            held_reg     <= '0;
            count_reg    <= '0;
            elapsed_reg  <= '0;
            sub_reg      <= '0;
            quarter_reg  <= '0;
            hold_reg     <= '0;
            idx_reg      <= '0;
            force_reg    <= 1'b0;
            pulse_reg    <= 1'b0;
            mismatch_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            count_reg    <= count_next;
            elapsed_reg  <= elapsed_next;
            sub_reg      <= sub_next;
            quarter_reg  <= quarter_next;
            hold_reg     <= hold_next;
            idx_reg      <= idx_next;
            force_reg    <= force_next;
            pulse_reg    <= pulse_next;
            mismatch_reg <= mismatch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_we)
        begin
            seq_mem[seq_waddr] <= seq_wdata;
        end
        levels_reg    <= levels_next;
        last_reg      <= last_next;
        acc_reg       <= acc_next;
        lamps_reg     <= lamps_next;
        ph_out_reg    <= ph_out_next;
        pulse_out_reg <= pulse_out_next;
    end

    assign lamps_lit    = lamps_reg;
    assign phase        = ph_out_reg;
    assign solved_pulse = pulse_out_reg;

endmodule

// ===== hdl/button_sequence_lock.sv =====
`timescale 1ns / 1ps
// Flow: an accepted item walks the buttons in use (only while the lock is entering),
// then the entries taken so far, then a judge step and a show step; the show step
// stalls while an earlier result still waits to be taken.
// Items are taken one at a time; the next item is taken while a result waits.
// Reset: asynchronous and active low; the lock returns to entering with no entries.

module button_sequence_lock
    import bsl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [LAMP_W-1:0] button_levels,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [LAMP_W-1:0] lamps_lit,
    output logic [1:0]        phase,
    output logic              solved_pulse,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [CNT_W-1:0]  button_count_reg;
    logic [CNT_W-1:0]  code_length_reg;
    logic [WORD_W-1:0] code_word_reg;
    logic [DUR_W-1:0]  wrong_ticks_reg;
    logic [DUR_W-1:0]  right_ticks_reg;
    logic [2:0]        reg_index;
    logic              wr_en;
    bsl_cmd_t          cmd;
    bsl_status_t       status;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_count_reg <= CNT_W'(8);
            code_length_reg  <= CNT_W'(4);
            code_word_reg    <= '0;
            wrong_ticks_reg  <= '0;
            right_ticks_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_BUTTON_COUNT: button_count_reg <= pwdata[CNT_W-1:0];
                REG_CODE_LENGTH:  code_length_reg  <= pwdata[CNT_W-1:0];
                REG_CODE_WORD:    code_word_reg    <= pwdata[WORD_W-1:0];
                REG_WRONG_TICKS:  wrong_ticks_reg  <= pwdata[DUR_W-1:0];
                REG_RIGHT_TICKS:  right_ticks_reg  <= pwdata[DUR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_BUTTON_COUNT: prdata = DATA_W'(button_count_reg);
            REG_CODE_LENGTH:  prdata = DATA_W'(code_length_reg);
            REG_CODE_WORD:    prdata = DATA_W'(code_word_reg);
            REG_WRONG_TICKS:  prdata = DATA_W'(wrong_ticks_reg);
            REG_RIGHT_TICKS:  prdata = DATA_W'(right_ticks_reg);
            default:          prdata = '0;
        endcase
    end

    bsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bsl_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .action           (action),
        .button_levels    (button_levels),
        .button_count     (button_count_reg),
        .code_length      (code_length_reg),
        .code_word        (code_word_reg),
        .wrong_show_ticks (wrong_ticks_reg),
        .right_show_ticks (right_ticks_reg),
        .lamps_lit        (lamps_lit),
        .phase            (phase),
        .solved_pulse     (solved_pulse)
    );

endmodule

// ===== hdl/bsl_checker.sv =====
`timescale 1ns / 1ps

module bsl_checker
    import bsl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [LAMP_W-1:0] lamps_lit,
    input logic [1:0]        phase,
    input logic              solved_pulse
);

    // A solve pulse only comes with the solved display or the solved hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && solved_pulse |-> (phase == PH_RIGHT) || (phase == PH_SOLVED))
    else $error("solve pulse outside a solved phase");

    // The lock works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");

    // No result rises and is taken straight after an item is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !(out_valid && out_ready) || !$rose(out_valid))
    else $error("result appeared too early after an item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lamps_lit) && $stable(phase)
                                    && $stable(solved_pulse))
    else $error("stalled result changed");

endmodule

bind button_sequence_lock bsl_checker u_bsl_checker (.*);

// ===== sim/lamp_phase_checker.sv =====
`timescale 1ns / 1ps

module lamp_phase_checker
    import bsl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        action,
    input  logic [LAMP_W-1:0] button_levels,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [LAMP_W-1:0] lamps_lit,
    input  logic [1:0]        phase,
    input  logic              solved_pulse,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                mismatches,
    output int                due_count
);

    localparam int HALF_WRONG = 500;
    localparam logic [DUR_W-1:0] ELAPSED_TOP = '1;

    typedef struct packed {
        logic [LAMP_W-1:0] lamps;
        phase_t            ph;
        logic              pulse;
    } lock_view_t;

    logic [CNT_W-1:0]  button_count_q;
    logic [CNT_W-1:0]  code_length_q;
    logic [WORD_W-1:0] code_word_q;
    logic [DUR_W-1:0]  wrong_ticks_q;
    logic [DUR_W-1:0]  right_ticks_q;

    phase_t                 lock_phase;
    logic [MAX_BUTTONS-1:0] held;
    logic [IDX_W-1:0]       entered [MAX_CODE];
    int                     entry_count;
    logic [DUR_W-1:0]       elapsed;
    logic [LAMP_W-1:0]      hold_lamps;
    int                     fail_total;

    lock_view_t lamp_phase_due [$];

    function automatic int buttons_in_use();
        if (button_count_q == 0)
            return 1;
        if (button_count_q > MAX_BUTTONS)
            return MAX_BUTTONS;
        return int'(button_count_q);
    endfunction

    function automatic int length_in_use();
        if (code_length_q == 0)
            return 1;
        if (code_length_q > MAX_CODE)
            return MAX_CODE;
        return int'(code_length_q);
    endfunction

    function automatic logic [IDX_W-1:0] code_digit(int pos);
        return code_word_q[DIGIT_W*pos +: DIGIT_W];
    endfunction

    task automatic step_lock(input logic [1:0] act, input logic [LAMP_W-1:0] lev,
                             output lock_view_t view);
        int                nb;
        int                len;
        int                i;
        logic [LAMP_W-1:0] mask;
        logic [LAMP_W-1:0] lamps;
        logic              pulse;
        logic              off_code;
        nb = buttons_in_use();
        len = length_in_use();
        mask = '0;
        for (i = 0; i < nb; i++)
            mask[i] = 1'b1;
        lamps = '0;
        pulse = 1'b0;
        if ((lock_phase == PH_WRONG || lock_phase == PH_RIGHT) && elapsed != ELAPSED_TOP)
            elapsed = elapsed + DUR_W'(1);
        if (act == ACT_FORCE)
        begin
            lock_phase = PH_RIGHT;
            elapsed = '0;
        end
        else
        begin
            if (act == ACT_RESTART)
            begin
                lock_phase = PH_ENTER;
                entry_count = 0;
                hold_lamps = '0;
            end
            if (lock_phase == PH_ENTER)
            begin
                // Buttons are walked in index order, so several releases in one
                // item append in ascending order.
                for (i = 0; i < nb; i++)
                begin
                    if (!lev[i] && !held[i])
                        held[i] = 1'b1;
                    else if (lev[i] && held[i])
                    begin
                        held[i] = 1'b0;
                        if (entry_count < len && (entry_count == 0 ||
                            entered[entry_count-1] != i[IDX_W-1:0]))
                        begin
                            entered[entry_count] = i[IDX_W-1:0];
                            entry_count++;
                        end
                    end
                end
                off_code = 1'b0;
                for (i = 0; i < entry_count; i++)
                    if (entered[i] != code_digit(i))
                        off_code = 1'b1;
                if (entry_count > 0 && off_code)
                begin
                    lock_phase = PH_WRONG;
                    elapsed = '0;
                end
                else if (entry_count > 0 && entry_count == len)
                begin
                    lock_phase = PH_RIGHT;
                    elapsed = '0;
                    pulse = 1'b1;
                end
            end
        end
        if (lock_phase == PH_WRONG)
        begin
            if (elapsed >= wrong_ticks_q)
            begin
                entry_count = 0;
                lock_phase = PH_ENTER;
            end
            else if ((elapsed / HALF_WRONG) % 2 == 0)
            begin
                for (i = 0; i < entry_count; i++)
                    lamps[entered[i]] = 1'b1;
            end
        end
        if (lock_phase == PH_RIGHT)
        begin
            if (elapsed >= right_ticks_q)
            begin
                hold_lamps = '0;
                for (i = 0; i < len; i++)
                    hold_lamps[i] = 1'b1;
                hold_lamps = hold_lamps & mask;
                lock_phase = PH_SOLVED;
            end
            else
            begin
                // Later positions override earlier ones that share a lamp.
                for (i = 0; i < len; i++)
                    lamps[code_digit(i)] = ((elapsed / HALF_RIGHT + i) % 2 == 0);
            end
        end
        if (lock_phase == PH_ENTER)
        begin
            for (i = 0; i < entry_count; i++)
                lamps[entered[i]] = 1'b1;
        end
        if (lock_phase == PH_SOLVED)
            lamps = hold_lamps;
        view.lamps = lamps & mask;
        view.ph = lock_phase;
        view.pulse = pulse;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lock_view_t due;
        lock_view_t fresh;
        int         k;
        if (!rst_n)
        begin
            button_count_q = 4'd8;
            code_length_q = 4'd4;
            code_word_q = '0;
            wrong_ticks_q = '0;
            right_ticks_q = '0;
            lock_phase = PH_ENTER;
            held = '0;
            for (k = 0; k < MAX_CODE; k++)
                entered[k] = '0;
            entry_count = 0;
            elapsed = '0;
            hold_lamps = '0;
            fail_total = 0;
            lamp_phase_due.delete();
            mismatches <= 0;
            due_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_BUTTON_COUNT: button_count_q = pwdata[CNT_W-1:0];
                    REG_CODE_LENGTH:  code_length_q = pwdata[CNT_W-1:0];
                    REG_CODE_WORD:    code_word_q = pwdata[WORD_W-1:0];
                    REG_WRONG_TICKS:  wrong_ticks_q = pwdata[DUR_W-1:0];
                    REG_RIGHT_TICKS:  right_ticks_q = pwdata[DUR_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (lamp_phase_due.size() == 0)
                begin
                    $display("%0t unexpected result: lamps_lit %02h phase %0d solved_pulse %0b",
                             $time, lamps_lit, phase, solved_pulse);
                    fail_total++;
                end
                else
                begin
                    due = lamp_phase_due.pop_front();
                    if (due.lamps != lamps_lit)
                    begin
                        $display("%0t lamps_lit mismatch: expected %02h, actual %02h",
                                 $time, due.lamps, lamps_lit);
                        fail_total++;
                    end
                    if (due.ph != phase)
                    begin
                        $display("%0t phase mismatch: expected %0d, actual %0d",
                                 $time, due.ph, phase);
                        fail_total++;
                    end
                    if (due.pulse != solved_pulse)
                    begin
                        $display("%0t solved_pulse mismatch: expected %0b, actual %0b",
                                 $time, due.pulse, solved_pulse);
                        fail_total++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                step_lock(action, button_levels, fresh);
                lamp_phase_due.push_back(fresh);
            end
            mismatches <= fail_total;
            due_count <= lamp_phase_due.size();
        end
    end

endmodule

// ===== sim/button_sequence_lock_tb.sv =====
`timescale 1ns / 1ps

module button_sequence_lock_tb;

    import bsl_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int ITEM_TARGET  = 1950;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [DUR_W-1:0] DUR_TOP = '1;

    typedef enum int {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_EVERY_FIFTH
    } ready_mode_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        action = ACT_SCAN;
    logic [LAMP_W-1:0] button_levels = '1;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [LAMP_W-1:0] lamps_lit;
    logic [1:0]        phase;
    logic              solved_pulse;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int mismatches;
    int due_count;

    int          items_sent = 0;
    int          burst_left = 0;
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          ready_left = 0;
    int          ready_tick = 0;

    int                gen_len = 4;
    logic [WORD_W-1:0] gen_word = '0;
    int                entry_pos = 0;
    int                hold_left = 0;
    int                rest_left = 0;
    bit                pressing = 1'b0;
    bit                quiet = 1'b0;
    logic [LAMP_W-1:0] cur_levels = '1;

    button_sequence_lock dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .button_levels(button_levels),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lamps_lit    (lamps_lit),
        .phase        (phase),
        .solved_pulse (solved_pulse),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    lamp_phase_checker lamp_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .button_levels(button_levels),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lamps_lit    (lamps_lit),
        .phase        (phase),
        .solved_pulse (solved_pulse),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .due_count    (due_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_left <= $urandom_range(50, 400);
        end
        else
            ready_left <= ready_left - 1;
        ready_tick <= ready_tick + 1;
        case (ready_mode)
            RDY_ALWAYS:  out_ready <= 1'b1;
            RDY_MOSTLY:  out_ready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY:  out_ready <= ($urandom_range(0, 3) == 0);
            default:     out_ready <= (ready_tick % 5 == 0);
        endcase
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic int clamp_count(input logic [CNT_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > 8)
            return 8;
        return int'(raw);
    endfunction

    function automatic logic [WORD_W-1:0] pick_code(input int nb);
        logic [WORD_W-1:0] word;
        int                prev;
        int                d;
        int                i;
        if ($urandom_range(0, 9) < 2)
            return WORD_W'($urandom());
        word = '0;
        prev = -1;
        for (i = 0; i < MAX_CODE; i++)
        begin
            d = $urandom_range(0, nb - 1);
            if (d == prev && nb > 1)
                d = (d + 1) % nb;
            word[DIGIT_W*i +: DIGIT_W] = d[DIGIT_W-1:0];
            prev = d;
        end
        return word;
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration(input int span);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return DUR_TOP;
        if (pick == 2)
            return $urandom();
        if (pick < 6)
            return $urandom_range(1, 20);
        return $urandom_range(1, span);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic [CNT_W-1:0] cnt, input logic [CNT_W-1:0] len,
                                 input logic [WORD_W-1:0] word,
                                 input logic [DUR_W-1:0] wrong_dur,
                                 input logic [DUR_W-1:0] right_dur);
        write_reg(REG_BUTTON_COUNT, DATA_W'(cnt));
        write_reg(REG_CODE_LENGTH, DATA_W'(len));
        write_reg(REG_CODE_WORD, DATA_W'(word));
        write_reg(REG_WRONG_TICKS, wrong_dur);
        write_reg(REG_RIGHT_TICKS, right_dur);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gen_len = clamp_count(len);
        gen_word = word;
        entry_pos = 0;
        hold_left = 0;
        rest_left = 0;
        pressing = 1'b0;
    endtask

    task automatic offer_item(input logic [1:0] act, input logic [LAMP_W-1:0] lev);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        action <= act;
        button_levels <= lev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Mostly a press and release of each code button in turn, with occasional
    // wrong buttons, random levels and out-of-band actions mixed in.
    task automatic make_item(output logic [1:0] act, output logic [LAMP_W-1:0] lev);
        int pick;
        int digit;
        pick = $urandom_range(0, 99);
        act = ACT_SCAN;
        if (!quiet && pick < 3)
        begin
            act = ACT_RESTART;
            entry_pos = 0;
        end
        else if (!quiet && pick < 5)
            act = ACT_FORCE;
        else if (pick < 7)
            act = ACT_SPARE;
        pick = $urandom_range(0, 99);
        if (rest_left > 0)
        begin
            rest_left--;
            cur_levels = '1;
            if (rest_left == 0 && $urandom_range(0, 9) < 8)
            begin
                act = ACT_RESTART;
                entry_pos = 0;
            end
        end
        else if (pick < 6)
        begin
            cur_levels = LAMP_W'($urandom_range(0, 255));
            pressing = 1'b0;
        end
        else if (!pressing)
        begin
            if ($urandom_range(0, 15) == 0)
                digit = $urandom_range(0, 7);
            else
                digit = int'(gen_word[DIGIT_W*entry_pos +: DIGIT_W]);
            cur_levels = ~(LAMP_W'(1) << digit);
            pressing = 1'b1;
            hold_left = $urandom_range(0, 2);
        end
        else if (hold_left > 0)
            hold_left--;
        else
        begin
            cur_levels = '1;
            pressing = 1'b0;
            entry_pos++;
            if (entry_pos >= gen_len)
            begin
                entry_pos = 0;
                rest_left = quiet ? $urandom_range(400, 800) : $urandom_range(1, 30);
            end
        end
        lev = cur_levels;
    endtask

    initial
    begin : stimulus
        logic [1:0]        act;
        logic [LAMP_W-1:0] lev;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  len;
        logic [WORD_W-1:0] word;
        logic [DUR_W-1:0]  wrong_dur;
        logic [DUR_W-1:0]  right_dur;
        int                phase_no;
        int                phase_items;
        int                i;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: code of all zeros, so a second zero is a repeated release.
        offer_item(ACT_SCAN, 8'hFE);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SCAN, 8'hFE);
        offer_item(ACT_SCAN, 8'hFF);

        // Four buttons, code 2, 0, 3, short displays.
        settle();
        load_settings(4'd4, 4'd3, 24'h0000C2, 32'd2, 32'd3);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SCAN, 8'hFB);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SCAN, 8'hFB);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SCAN, 8'hFE);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SCAN, 8'h77);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_RESTART, 8'h00);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SCAN, 8'hFF);
        offer_item(ACT_SPARE, 8'hFD);
        offer_item(ACT_FORCE, 8'hFF);
        offer_item(ACT_RESTART, 8'hFF);
        offer_item(ACT_SCAN, 8'h00);

        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase_no)
                0:
                begin
                    cnt = 4'd1;
                    len = 4'd1;
                end
                1:
                begin
                    cnt = 4'd8;
                    len = 4'd8;
                end
                2:
                begin
                    cnt = 4'd0;
                    len = 4'd0;
                end
                3:
                begin
                    cnt = 4'd15;
                    len = 4'd15;
                end
                default:
                begin
                    cnt = ($urandom_range(0, 99) < 85) ? CNT_W'($urandom_range(1, 8))
                                                       : CNT_W'($urandom_range(0, 15));
                    len = ($urandom_range(0, 99) < 85) ? CNT_W'($urandom_range(1, 8))
                                                       : CNT_W'($urandom_range(0, 15));
                end
            endcase
            word = pick_code(clamp_count(cnt));
            if (phase_no == 2)
                word = '0;
            if (phase_no == 3)
                word = '1;
            quiet = (phase_no == 5);
            if (phase_no == 4)
            begin
                wrong_dur = DUR_TOP;
                right_dur = DUR_TOP;
            end
            else if (quiet)
            begin
                wrong_dur = 32'd700;
                right_dur = 32'd400;
            end
            else
            begin
                wrong_dur = pick_duration(1200);
                right_dur = pick_duration(600);
            end
            phase_items = quiet ? 650 : $urandom_range(60, 200);

            settle();
            load_settings(cnt, len, word, wrong_dur, right_dur);
            for (i = 0; i < phase_items && items_sent < ITEM_TARGET; i++)
            begin
                if (i == 0)
                begin
                    act = ACT_RESTART;
                    lev = '1;
                    cur_levels = '1;
                end
                else
                    make_item(act, lev);
                offer_item(act, lev);
            end
            phase_no++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
